/* hw/rtl/fir_filter_13_tap_adc_core_macros.svh */
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_13_TAP_ADC_CORE_MACROS_SVH
`define FIR_FILTER_13_TAP_ADC_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIR13_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FIR13_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fir13_pkg.sv */
// ----------------------------------------------------------------------------
// fir13_pkg
// Widths, constants, control types and the tap-to-coefficient mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package fir13_pkg;

    localparam int ADC_W       = 12;
    localparam int SAMPLE_W    = 13;
    localparam int COEF_W      = 16;
    localparam int ACC_W       = 16;
    localparam int FRAC_W      = 15;
    localparam int PROD_W      = COEF_W + SAMPLE_W;
    localparam int SUM_W       = ACC_W + FRAC_W + 2;
    localparam int QUOT_W      = SUM_W - FRAC_W;
    localparam int ADC_OFFSET  = 512;

    localparam int COEF_REGS   = 7;
    localparam int COEF_IDX_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = COEF_W;

    localparam int DEFAULT_TAP_COUNT = 13;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TAP_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_CENTER = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_RESET [COEF_REGS] = '{
        16'sd3163, -16'sd513, -16'sd1642, -16'sd3217,
        -16'sd4828, -16'sd6026, 16'sd26299
    };

    typedef struct packed {
        logic shift;
        logic rotate;
    } fir13_cell_ctl_t;

    typedef struct packed {
        logic clear;
        logic issue;
    } fir13_mac_ctl_t;

    // Taps mirror around the center; distances past the last edge register
    // all share the center coefficient.
    function automatic logic [COEF_IDX_W-1:0] coef_sel(input int tap, input int taps);
        int mirror;
        mirror = taps - 1 - tap;
        if (tap < mirror)
            mirror = tap;
        if (mirror >= COEF_REGS - 1)
            return COEF_IDX_W'(COEF_REGS - 1);
        return COEF_IDX_W'(mirror);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fir13_cell.sv */
// ----------------------------------------------------------------------------
// fir13_cell
// One sample of the history line: shifts in on a new item, rotates while
// the taps are walked.
// ----------------------------------------------------------------------------
`default_nettype none

module fir13_cell
    import fir13_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fir13_cell_ctl_t            ctl,
    input  wire logic signed [SAMPLE_W-1:0] shift_in,
    input  wire logic signed [SAMPLE_W-1:0] rot_in,
    output logic signed [SAMPLE_W-1:0]      sample
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;

    always_comb
    begin
        sample_next = sample_reg;
        if (ctl.shift)
            sample_next = shift_in;
        else if (ctl.rotate)
            sample_next = rot_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_reg <= '0;
        else
            sample_reg <= sample_next;
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

/* hw/rtl/fir13_mac.sv */
// ----------------------------------------------------------------------------
// fir13_mac
// Multiply-accumulate with per-tap truncation toward zero and 16-bit
// saturation. The product is registered before it is accumulated.
// ----------------------------------------------------------------------------
`default_nettype none

module fir13_mac
    import fir13_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fir13_mac_ctl_t             ctl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [COEF_W-1:0]   coef,
    output logic signed [ACC_W-1:0]         acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic [SUM_W-1:0]         sum_w;
    logic                     round_up;
    logic [QUOT_W-1:0]        quot_w;
    logic                     over_hi;
    logic                     over_lo;
    logic signed [ACC_W-1:0]  sat_w;

    assign prod_next = sample * coef;

    always_comb
    begin
        sum_w = {{(SUM_W - ACC_W - FRAC_W){acc_reg[ACC_W-1]}}, acc_reg, {FRAC_W{1'b0}}}
              + {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        // An arithmetic shift floors; a negative sum with a fraction left
        // must step back up by one to truncate toward zero.
        round_up = sum_w[SUM_W-1] && (sum_w[FRAC_W-1:0] != '0);
        quot_w   = sum_w[SUM_W-1:FRAC_W] + {{(QUOT_W-1){1'b0}}, round_up};
        over_hi  = !quot_w[QUOT_W-1] && (quot_w[QUOT_W-2:ACC_W-1] != '0);
        over_lo  = quot_w[QUOT_W-1] && (quot_w[QUOT_W-2:ACC_W-1] != '1);
        if (over_hi)
            sat_w = {1'b0, {(ACC_W-1){1'b1}}};
        else if (over_lo)
            sat_w = {1'b1, {(ACC_W-1){1'b0}}};
        else
            sat_w = quot_w[ACC_W-1:0];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (prod_valid_reg)
            acc_next = sat_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctl.issue;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
            prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* hw/rtl/fir_filter_13_tap_adc_core.sv */
// ----------------------------------------------------------------------------
// fir_filter_13_tap_adc_core
// Symmetric FIR over offset-corrected 12-bit ADC codes, one result per item.
// ----------------------------------------------------------------------------
// Usage:
// An item on the input channel (in_valid/in_ready, adc_code) is one converter
// code. It has 512 subtracted and is shifted into a chain of TAP_COUNT sample
// cells. The chain then rotates once around while a single multiply-
// accumulate unit walks the taps from newest to oldest, one tap per cycle.
// The result leaves on the output channel (out_valid/out_ready,
// filtered_sample) after the tap walk, a drain step and a done step.
// The block works on one item at a time: in_ready is high only while the
// unit is idle, so a new item is taken only once the last one is done.
// A result waiting in the output register does not block the next item; if
// a new result is finished before the old one is taken, it is held until
// out_ready frees the output register.
// The seven coefficient registers are written through cfg_we, cfg_index and
// cfg_data; indexes above six are ignored. The user must write them only
// while the block is idle; the block itself does not enforce this.
// Reset clears the sample history to zero and loads default coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fir_filter_13_tap_adc_core_macros.svh"

module fir_filter_13_tap_adc_core
    import fir13_pkg::*;
#(
    parameter int TAP_COUNT = DEFAULT_TAP_COUNT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [ADC_W-1:0]        adc_code,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [ACC_W-1:0]      filtered_sample,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int TAP_IDX_W = $clog2(TAP_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [TAP_IDX_W-1:0]        tap_cnt_reg;
    logic [TAP_IDX_W-1:0]        tap_cnt_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [ACC_W-1:0]     filtered_sample_reg;
    logic signed [ACC_W-1:0]     filtered_sample_next;

    logic signed [COEF_W-1:0]    coef_reg [COEF_REGS];

    logic                        accept;
    logic                        out_free;
    logic signed [SAMPLE_W-1:0]  new_sample;
    logic signed [SAMPLE_W-1:0]  cell_q [TAP_COUNT];
    logic signed [COEF_W-1:0]    coef_w;
    logic signed [ACC_W-1:0]     acc_w;
    fir13_cell_ctl_t             cell_ctl;
    fir13_mac_ctl_t              mac_ctl;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign new_sample = {1'b0, adc_code} - SAMPLE_W'(ADC_OFFSET);

    assign cell_ctl.shift  = accept;
    assign cell_ctl.rotate = (state_reg == ST_RUN);
    assign mac_ctl.clear   = accept;
    assign mac_ctl.issue   = (state_reg == ST_RUN);

    // Cell 0 always presents the tap being worked on; the chain rotates
    // toward it and is back in order when the tap walk is over.
    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == TAP_COUNT - 1) ? 0 : i + 1;

        fir13_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .shift_in ((i == 0) ? new_sample : cell_q[PREV]),
            .rot_in   (cell_q[NEXT]),
            .sample   (cell_q[i])
        );
    end

    assign coef_w = coef_reg[coef_sel(int'(tap_cnt_reg), TAP_COUNT)];

    fir13_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (cell_q[0]),
        .coef   (coef_w),
        .acc    (acc_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < COEF_REGS; k++)
                coef_reg[k] <= COEF_RESET[k];
        end
        else if (cfg_we && (cfg_index <= REG_TAP_CENTER))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        tap_cnt_next         = tap_cnt_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        filtered_sample_next = filtered_sample_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_RUN;
                    tap_cnt_next = '0;
                end
            end
            ST_RUN:
            begin
                if (tap_cnt_reg == TAP_IDX_W'(TAP_COUNT - 1))
                    state_next = ST_WAIT;
                else
                    tap_cnt_next = tap_cnt_reg + 1'b1;
            end
            ST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    filtered_sample_next = acc_w;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            tap_cnt_reg         <= '0;
            out_valid_reg       <= 1'b0;
            filtered_sample_reg <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            tap_cnt_reg         <= tap_cnt_next;
            out_valid_reg       <= out_valid_next;
            filtered_sample_reg <= filtered_sample_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = filtered_sample_reg;

    `FIR13_ASSERT_NEXT(a_start_run, accept, (state_reg == ST_RUN) && (tap_cnt_reg == '0), "accepted item did not start the tap walk")
    `FIR13_ASSERT_IMPL(a_tap_bound, state_reg == ST_RUN, tap_cnt_reg <= TAP_IDX_W'(TAP_COUNT - 1), "tap counter ran past the last tap")
    `FIR13_ASSERT_IMPL(a_wait_after_last, state_reg == ST_WAIT, ($past(state_reg) == ST_RUN) && ($past(tap_cnt_reg) == TAP_IDX_W'(TAP_COUNT - 1)), "drain entered before the last tap")
    `FIR13_ASSERT_IMPL(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE, "result raised outside the done step")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// FIR filter core testbench
// Drives ADC codes through the 13-tap symmetric FIR core and checks every
// filtered sample against a cycle-free predictor of the same arithmetic:
// offset removal, sample history, per-tap truncation and 16-bit clamping.
// Coefficient registers are reloaded between phases while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import fir13_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS         = DEFAULT_TAP_COUNT;
    localparam int SETTLE_CYCLES = TAPS + 5;
    localparam int CYCLE_LIMIT  = 400000;

    // Index past the last coefficient register; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [ADC_W-1:0]      adc_code  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [ACC_W-1:0] filtered_sample;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    fir_filter_13_tap_adc_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .adc_code        (adc_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Predictor state: coefficients and the sample history, newest first.
    logic signed [COEF_W-1:0]   coef [COEF_REGS];
    logic signed [SAMPLE_W-1:0] history [TAPS];

    logic signed [ACC_W-1:0] expected_samples [$];
    reg_write_t              pending_writes [$];

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    logic rx_hold     = 1'b0;
    int  error_count  = 0;
    int  result_count = 0;
    int  cycle_count  = 0;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Shifts one code into the history and runs the taps newest to oldest,
    // truncating toward zero and clamping after every tap.
    function automatic logic signed [ACC_W-1:0] fir_response(input logic [ADC_W-1:0] code);
        longint acc;
        longint sum;
        int     mirror;
        int     sel;
        acc = 0;
        for (int i = TAPS - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = SAMPLE_W'($signed({1'b0, code}) - ADC_OFFSET);
        for (int t = 0; t < TAPS; t++)
        begin
            mirror = TAPS - 1 - t;
            if (t < mirror)
                mirror = t;
            sel = (mirror >= COEF_REGS - 1) ? COEF_REGS - 1 : mirror;
            sum = acc * 32768 + longint'(coef[sel]) * longint'(history[t]);
            acc = sum / 32768;
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
        end
        return ACC_W'(acc);
    endfunction

    function automatic void queue_write(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.index = index;
        w.data  = data;
        pending_writes.push_back(w);
    endfunction

    function automatic void queue_all_taps(input logic [CFG_DATA_W-1:0] data);
        for (int i = 0; i < COEF_REGS; i++)
            queue_write(REG_TAP_0 + CFG_IDX_W'(i), data);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(2047)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ADC_W-1:0] pick_code();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return ADC_W'(ADC_OFFSET);
            default: return ADC_W'($urandom_range(4095));
        endcase
    endfunction

    // Called at a rising edge while the core is idle.
    task automatic write_registers();
        reg_write_t w;
        while (pending_writes.size() != 0)
        begin
            w = pending_writes.pop_front();
            cfg_we    <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            if (w.index < COEF_REGS)
                coef[w.index] = signed'(w.data);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic [ADC_W-1:0] code);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_samples.push_back(fir_response(code));
    endtask

    // Lowers valid and waits until every expected sample has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // Default coefficients after reset, field extremes and the zero point.
    task automatic test_reset_coefficients();
        logic [ADC_W-1:0] codes [] = '{12'd0, 12'd4095, 12'd512, 12'd511, 12'd513,
                                       12'hAAA, 12'h555, 12'd4095, 12'd0};
        foreach (codes[i])
            send_item(codes[i]);
        drain();
    endtask

    // Full-scale coefficients drive the running sum past 16 bits both ways.
    task automatic test_saturation();
        queue_all_taps(16'h7FFF);
        write_registers();
        for (int i = 0; i < 8; i++)
            send_item(12'd4095);
        drain();
        // The write to the unused index must leave the taps alone.
        queue_all_taps(16'h8000);
        queue_write(REG_UNUSED, 16'h1234);
        write_registers();
        send_item(12'd4095);
        send_item(12'd4095);
        send_item(12'd0);
        send_item(12'd0);
        drain();
    endtask

    task automatic test_random_phase(input int items, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < COEF_REGS; i++)
            queue_write(REG_TAP_0 + CFG_IDX_W'(i), pick_coef());
        queue_write(REG_UNUSED, 16'($urandom));
        write_registers();
        for (int i = 0; i < items; i++)
            send_item(pick_code());
        drain();
    endtask

    // The receiver holds off long enough for the core to fill and stall input.
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        queue_write(REG_TAP_CENTER, 16'd16384);
        write_registers();
        fork
            hold_receiver(400);
        join_none
        for (int i = 0; i < 40; i++)
            send_item(pick_code());
        drain();
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch($sformatf("unexpected sample %0d", filtered_sample));
            else if (filtered_sample !== expected_samples[0])
            begin
                report_mismatch($sformatf("sample %0d: got %0d, expected %0d",
                                          result_count, filtered_sample,
                                          expected_samples[0]));
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
            result_count++;
        end
    end

    always @(posedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < COEF_REGS; i++)
            coef[i] = COEF_RESET[i];
        for (int i = 0; i < TAPS; i++)
            history[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefficients();
        test_saturation();
        test_random_phase(250, 19, 46);
        test_random_phase(250, 46, 19);
        test_random_phase(250, 0, 0);
        test_backpressure();

        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

/* fir_filter_13_tap_adc_core.f */
+incdir+hw/rtl
hw/rtl/fir13_pkg.sv
hw/rtl/fir13_cell.sv
hw/rtl/fir13_mac.sv
hw/rtl/fir_filter_13_tap_adc_core.sv
tb/tb_top.sv
